### sv/held_lock_deadlock_checker_assert.svh
// Assertion macros used by the held-lock checker's assertion file.
// Depends on nothing; take it in with a plain include.
`ifndef HELD_LOCK_DEADLOCK_CHECKER_ASSERT_SVH
`define HELD_LOCK_DEADLOCK_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HLDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("held lock checker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HLDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("held lock checker assertion failed");

`endif

### sv/hldc_pkg.sv
// Shared types and constants of the held-lock deadlock checker.
// Used by every module of the block but hldc_ram; depends on nothing.
package hldc_pkg;

  localparam int THREADS_DEF   = 8;
  localparam int LPT_DEF       = 8;
  localparam int ID_BITS_DEF   = 32;

  localparam int TID_W    = 3;
  localparam int LOCK_W   = 32;
  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SELF     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CROSS    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_HELD = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch request, read own row
    logic own;      // own row on read data, start scan
    logic clear;    // drop the matching slot
    logic scan;     // evaluate one thread row, read the next
    logic write;    // store lock in lowest free slot
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic hit;        // requesting thread holds the lock
    logic cross_blk;  // another thread blocks the acquire
    logic full;       // every slot of the thread is taken
    logic scan_last;  // scan is on the last thread
  } sts_t;

endpackage

### sv/hldc_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module hldc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/hldc_ctrl.sv
// Sequencer of the held-lock checker: own-row check, thread scan, update.
// Depends on hldc_pkg; drives hldc_datapath through cmd_t / sts_t.
module hldc_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           req_type_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [hldc_pkg::STATUS_W-1:0]  status_o,
  output hldc_pkg::cmd_t                 cmd_o,
  input  hldc_pkg::sts_t                 sts_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_OWN  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                      state_q, state_d;
  logic                            rel_q, rel_d;
  logic                            done_q, done_d;
  logic [hldc_pkg::STATUS_W-1:0]   status_q, status_d;

  always_comb begin
    state_d  = state_q;
    rel_d    = rel_q;
    done_d   = 1'b0;
    status_d = status_q;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          rel_d         = req_type_i;
          state_d       = S_OWN;
        end
      end
      S_OWN: begin
        cmd_o.own = 1'b1;
        if (rel_q == hldc_pkg::REQ_RELEASE) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (sts_i.hit) begin
            cmd_o.clear = 1'b1;
            status_d    = hldc_pkg::ST_OK;
          end else begin
            status_d = hldc_pkg::ST_NOT_HELD;
          end
        end else if (sts_i.hit) begin
          done_d   = 1'b1;
          status_d = hldc_pkg::ST_SELF;
          state_d  = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (sts_i.cross_blk) begin
          status_d = hldc_pkg::ST_CROSS;
        end else if (sts_i.full) begin
          status_d = hldc_pkg::ST_FULL;
        end else begin
          cmd_o.write = 1'b1;
          status_d    = hldc_pkg::ST_OK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rel_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rel_q   <= rel_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;

endmodule

### sv/hldc_datapath.sv
// Datapath of the held-lock checker: lock RAM (one row per thread), valid
// bits, slot compares and the scan counter. Depends on hldc_pkg, hldc_ram.
module hldc_datapath #(
  parameter int THREADS          = hldc_pkg::THREADS_DEF,
  parameter int LOCKS_PER_THREAD = hldc_pkg::LPT_DEF,
  parameter int LOCK_ID_BITS     = hldc_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [hldc_pkg::TID_W-1:0]    thread_id_i,
  input  logic [hldc_pkg::LOCK_W-1:0]   lock_id_i,
  input  hldc_pkg::cmd_t                cmd_i,
  output hldc_pkg::sts_t                sts_o
);

  localparam int TW  = $clog2(THREADS);
  localparam int LPT = LOCKS_PER_THREAD;
  localparam int IDW = LOCK_ID_BITS;
  localparam int RW  = LPT * IDW;

  logic [TW-1:0]          me_q;
  logic [IDW-1:0]         id_q;
  logic [RW-1:0]          own_q;
  logic [TW-1:0]          cnt_q;
  logic                   cross_q;
  logic [THREADS*LPT-1:0] valid_q;

  logic [6:0]             tmod;
  logic [TW-1:0]          tid;
  logic [TW-1:0]          raddr;
  logic [RW-1:0]          rdata;
  logic [RW-1:0]          new_row;
  logic [LPT-1:0]         own_v;
  logic [LPT-1:0]         row_v;
  logic [LPT-1:0]         hit_vec;
  logic [LPT-1:0]         free_oh;
  logic [LPT-1:0]         row_has_id;
  logic [LPT-1:0]         row_shares;
  logic                   scan_last;
  logic                   cross_hit;

  // Fold the thread number into range; it is at most 7, so a few subtracts do.
  always_comb begin
    tmod = 7'(thread_id_i);
    for (int k = 0; k < 4; k++) begin
      if (tmod >= 7'(THREADS)) begin
        tmod = tmod - 7'(THREADS);
      end
    end
    tid = TW'(tmod);
  end

  assign own_v     = valid_q[me_q*LPT +: LPT];
  assign row_v     = valid_q[cnt_q*LPT +: LPT];
  assign scan_last = (cnt_q == TW'(THREADS - 1));

  always_comb begin
    if (cmd_i.capture) begin
      raddr = tid;
    end else if (cmd_i.scan && !scan_last) begin
      raddr = cnt_q + TW'(1);
    end else begin
      raddr = '0;
    end
  end

  // Own row compare (valid only while the own row is on the read data).
  always_comb begin
    for (int j = 0; j < LPT; j++) begin
      hit_vec[j] = own_v[j] && (rdata[j*IDW +: IDW] == id_q);
    end
  end

  // Scanned thread: holds the new lock, and holds one of ours.
  always_comb begin
    for (int j = 0; j < LPT; j++) begin
      row_has_id[j] = row_v[j] && (rdata[j*IDW +: IDW] == id_q);
      row_shares[j] = 1'b0;
      for (int i = 0; i < LPT; i++) begin
        if (own_v[i] && (own_q[i*IDW +: IDW] == rdata[j*IDW +: IDW])) begin
          row_shares[j] = row_v[j];
        end
      end
    end
    cross_hit = (cnt_q != me_q) && (|row_has_id) && (|row_shares);
  end

  assign free_oh = ~own_v & (own_v + LPT'(1));

  always_comb begin
    for (int j = 0; j < LPT; j++) begin
      new_row[j*IDW +: IDW] = free_oh[j] ? id_q : own_q[j*IDW +: IDW];
    end
  end

  hldc_ram #(
    .WIDTH (RW),
    .DEPTH (THREADS)
  ) u_lock_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (me_q),
    .wdata_i (new_row),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      me_q <= tid;
      id_q <= IDW'(lock_id_i);
    end
    if (cmd_i.own) begin
      own_q <= rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
      cross_q <= 1'b0;
    end else begin
      if (cmd_i.own) begin
        cnt_q   <= '0;
        cross_q <= 1'b0;
      end else if (cmd_i.scan) begin
        cnt_q   <= cnt_q + TW'(1);
        cross_q <= cross_q | cross_hit;
      end
      if (cmd_i.clear) begin
        valid_q[me_q*LPT +: LPT] <= own_v & ~hit_vec;
      end else if (cmd_i.write) begin
        valid_q[me_q*LPT +: LPT] <= own_v | free_oh;
      end
    end
  end

  assign sts_o.hit       = |hit_vec;
  assign sts_o.cross_blk = cross_q;
  assign sts_o.full      = &own_v;
  assign sts_o.scan_last = scan_last;

endmodule

### sv/held_lock_deadlock_checker.sv
// Top level of the held-lock deadlock checker.
// Depends on hldc_pkg, hldc_ctrl, hldc_datapath (and hldc_ram below it).
//
// A request is taken on a clock edge with start_i high and busy_o low. A
// release, or an acquire of a lock the thread already holds, ends after the
// own-row check; any other acquire then walks every thread's row for the
// cross check, since the lock RAM gives one thread's row per cycle, and
// stores the lock if no other thread blocks it and a slot is free. The
// status appears on status_o with done_o high for exactly one cycle, in the
// first cycle with busy_o low; there is no backpressure, so sample it then. A
// new request may start in that same cycle. After reset no thread holds a lock.
module held_lock_deadlock_checker #(
  parameter int THREADS          = hldc_pkg::THREADS_DEF,
  parameter int LOCKS_PER_THREAD = hldc_pkg::LPT_DEF,
  parameter int LOCK_ID_BITS     = hldc_pkg::ID_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          req_type_i,
  input  logic [hldc_pkg::TID_W-1:0]    thread_id_i,
  input  logic [hldc_pkg::LOCK_W-1:0]   lock_id_i,
  output logic                          done_o,
  output logic [hldc_pkg::STATUS_W-1:0] status_o
);

  hldc_pkg::cmd_t cmd;
  hldc_pkg::sts_t sts;

  hldc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .status_o   (status_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  hldc_datapath #(
    .THREADS          (THREADS),
    .LOCKS_PER_THREAD (LOCKS_PER_THREAD),
    .LOCK_ID_BITS     (LOCK_ID_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thread_id_i (thread_id_i),
    .lock_id_i   (lock_id_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

### sv/hldc_checker.sv
// Port-level assertions for the held-lock deadlock checker, bound to the top.
// Depends on hldc_pkg and held_lock_deadlock_checker_assert.svh.
`include "held_lock_deadlock_checker_assert.svh"

module hldc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_i,
  input logic                          done_i,
  input logic [hldc_pkg::STATUS_W-1:0] status_i
);

  // Each transfer starts work; a result only follows work and comes back idle.
  `HLDC_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_i, busy_i)
  `HLDC_ASSERT_NOW(a_done_after_busy, clk_i, rst_ni, done_i, $past(busy_i) && !busy_i)
  `HLDC_ASSERT_NOW(a_status_code, clk_i, rst_ni, done_i, status_i <= hldc_pkg::ST_FULL)
  `HLDC_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_i, !done_i)

endmodule

bind held_lock_deadlock_checker hldc_checker u_hldc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_i   (busy_o),
  .done_i   (done_o),
  .status_i (status_o)
);
